/* sv/qfts_pkg.sv */
// Shared types and constants for the two-stack queue.
// Used by the controller, the datapath and the top level; no dependencies.
package qfts_pkg;

  // Default number of entries in each stack
  localparam int unsigned STACK_DEPTH_DEF = 8;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Value returned by a dequeue on an empty queue
  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_POP,
    ST_RESP
  } state_e;

  // Result register load selections
  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_FULL,
    RES_EMPTY
  } res_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    push;
    logic    mv_rd;
    logic    mv_wr;
    logic    pop_rd;
    logic    load_out;
    res_op_e res_op;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_full;
    logic in_empty;
    logic out_empty;
    logic mv_pend;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/qfts_ctrl.sv */
// Controller state machine for the two-stack queue.
// Depends on qfts_pkg; drives commands into qfts_dp.
module qfts_ctrl import qfts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_cmd_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.res_op = RES_NONE;
    in_stall_o   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_ENQ) begin
            // push, or drop the word when the input stack is full
            if (status_i.in_full) begin
              cmd_o.res_op = RES_FULL;
            end else begin
              cmd_o.push   = 1'b1;
              cmd_o.res_op = RES_OK;
            end
            state_d = ST_RESP;
          end else if (!status_i.out_empty) begin
            state_d = ST_POP;
          end else if (!status_i.in_empty) begin
            state_d = ST_MOVE;
          end else begin
            cmd_o.res_op = RES_EMPTY;
            state_d      = ST_RESP;
          end
        end
      end
      ST_MOVE: begin
        // read one entry and write the previous one each cycle
        cmd_o.mv_rd = !status_i.in_empty;
        cmd_o.mv_wr = status_i.mv_pend;
        if (status_i.in_empty && !status_i.mv_pend) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register can take the word
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/qfts_dp.sv */
// Datapath for the two-stack queue: both stack memories, counts,
// result register and output register. Depends on qfts_pkg.
module qfts_dp import qfts_pkg::*; #(
  parameter int unsigned StackDepth = STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_word_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_word_t  out_word_o
);

  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam int unsigned AW = $clog2(StackDepth);

  logic [31:0]        in_mem  [StackDepth];
  logic [31:0]        out_mem [StackDepth];
  logic [CW-1:0]      in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
  logic [CW-1:0]      in_top, out_top;
  logic [31:0]        mv_data_q;
  logic               mv_pend_q;
  logic signed [31:0] res_val_q;
  logic [1:0]         res_st_q;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q;

  assign in_top  = in_cnt_q - CW'(1);
  assign out_top = out_cnt_q - CW'(1);

  // Push into the input stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      in_mem[in_cnt_q[AW-1:0]] <= in_word_i.value;
    end
  end

  // Read the top of the input stack during a move
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_rd) begin
      mv_data_q <= in_mem[in_top[AW-1:0]];
    end
  end

  // Write the moved word onto the output stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_wr) begin
      out_mem[out_cnt_q[AW-1:0]] <= mv_data_q;
    end
  end

  // Result register: pop read or fixed result
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_rd) begin
      res_val_q <= out_mem[out_top[AW-1:0]];
      res_st_q  <= STATUS_OK;
    end else begin
      case (cmd_i.res_op)
        RES_OK: begin
          res_val_q <= '0;
          res_st_q  <= STATUS_OK;
        end
        RES_FULL: begin
          res_val_q <= '0;
          res_st_q  <= STATUS_FULL;
        end
        RES_EMPTY: begin
          res_val_q <= EMPTY_VALUE;
          res_st_q  <= STATUS_EMPTY;
        end
        default: begin
          res_val_q <= res_val_q;
          res_st_q  <= res_st_q;
        end
      endcase
    end
  end

  // Advance the counts
  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    if (cmd_i.push) begin
      in_cnt_d = in_cnt_q + CW'(1);
    end else if (cmd_i.mv_rd) begin
      in_cnt_d = in_top;
    end
    if (cmd_i.mv_wr) begin
      out_cnt_d = out_cnt_q + CW'(1);
    end else if (cmd_i.pop_rd) begin
      out_cnt_d = out_top;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      mv_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      mv_pend_q   <= cmd_i.mv_rd;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the outgoing word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_word_q.result_value <= res_val_q;
      out_word_q.status       <= res_st_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_word_o         = out_word_q;
  assign status_o.in_full   = (in_cnt_q == CW'(StackDepth));
  assign status_o.in_empty  = (in_cnt_q == '0);
  assign status_o.out_empty = (out_cnt_q == '0);
  assign status_o.mv_pend   = mv_pend_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

/* sv/queue_from_two_stacks.sv */
// FIFO queue built from two stacks of StackDepth entries each.
// Enqueue: result register, then output register. Dequeue: when the output
// stack is empty, the words on the input stack are first moved onto it (one
// word moved per cycle via the stack memory ports); then the top is popped
// into the result register and then the output register. One word is worked
// on at a time. Reset clears both counts and the controller, not the stacks.
module queue_from_two_stacks import qfts_pkg::*; #(
  parameter int unsigned StackDepth = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  qfts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_cmd_i   (in_word_i.command),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Stacks and result path
  qfts_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

/* tb/queue_from_two_stacks_tb.sv */
// Self-checking testbench for queue_from_two_stacks: directed table, then random
// enqueue/dequeue traffic with random idling on both sides. Needs qfts_pkg.
`timescale 1ns / 1ps

module queue_from_two_stacks_tb;
  import qfts_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int RAND_ITEMS = 2000;
  localparam int PAUSE_AT = 1200;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  // One row of the directed table; want is used only where typed is set
  typedef struct {
    logic      cmd;
    logic [31:0] val;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_word_t out_word_o;

  // Predictor state
  logic signed [31:0] in_mem[DEPTH];
  logic signed [31:0] out_mem[DEPTH];
  int unsigned        in_cnt = 0;
  int unsigned        out_cnt = 0;

  out_word_t owed_words[$];
  int        err_cnt = 0;
  bit        tx_quiet = 1'b0;
  dir_row_t  dir_tab[$];

  queue_from_two_stacks u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the two-stack queue by one command and return its result word
  function automatic out_word_t two_stack_step(input logic cmd, input logic signed [31:0] val);
    out_word_t r;
    r.result_value = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_ENQ) begin
      if (in_cnt >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        in_mem[in_cnt] = val;
        in_cnt++;
      end
    end else begin
      // refill only when the output stack has run dry, keeping FIFO order
      if (out_cnt == 0) begin
        while (in_cnt > 0 && out_cnt < DEPTH) begin
          in_cnt--;
          out_mem[out_cnt] = in_mem[in_cnt];
          out_cnt++;
        end
      end
      if (out_cnt == 0) begin
        r.result_value = EMPTY_VALUE;
        r.status = STATUS_EMPTY;
      end else begin
        out_cnt--;
        r.result_value = out_mem[out_cnt];
      end
    end
    return r;
  endfunction

  // Offer one word after a random gap, hold it until taken, then log its result
  task automatic send_word(input logic cmd, input logic [31:0] val, input bit typed,
                           input out_word_t want);
    int gap;
    out_word_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_word_i.command <= cmd;
    in_word_i.value <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    pred = two_stack_step(cmd, val);
    owed_words.push_back(typed ? want : pred);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] edges[5];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 4)];
    return $urandom;
  endfunction

  // Sender: reset, directed table, random traffic, drain and verdict
  initial begin
    int  bias;
    logic cmd;
    dir_table_fill: begin
      dir_tab = '{
        '{CMD_DEQ, 32'hFFFF_FFFF, 1'b1, '{EMPTY_VALUE, STATUS_EMPTY}},
        '{CMD_ENQ, 32'h8000_0000, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'h7FFF_FFFF, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'h0000_0000, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'hFFFF_FFFF, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'h0000_0001, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'h5555_5555, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'hAAAA_AAAA, 1'b1, '{32'sd0, STATUS_OK}},
        '{CMD_ENQ, 32'h1234_5678, 1'b1, '{32'sd0, STATUS_OK}},
        // input stack full: value dropped
        '{CMD_ENQ, 32'hDEAD_BEEF, 1'b1, '{32'sd0, STATUS_FULL}},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'hFFFF_FFFF, 1'b0, '0},
        // push while the output stack still holds data
        '{CMD_ENQ, 32'h0F0F_0F0F, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEQ, 32'hFFFF_FFFF, 1'b1, '{EMPTY_VALUE, STATUS_EMPTY}}
      };
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      send_word(dir_tab[k].cmd, dir_tab[k].val, dir_tab[k].typed, dir_tab[k].want);
    end

    bias = 50;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      // switch the enqueue mix and the idling mode every few dozen words
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 25;
          1: bias = 50;
          default: bias = 75;
        endcase
        tx_quiet = ($urandom_range(0, 3) == 0);
      end
      // hold off until every owed result has come back
      if (i == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        while (owed_words.size() != 0) @(posedge clk_i);
      end
      cmd = ($urandom_range(0, 99) < bias) ? CMD_ENQ : CMD_DEQ;
      send_word(cmd, pick_value(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("queue_from_two_stacks_tb OK");
    end else begin
      $display("queue_from_two_stacks_tb NOT OK");
    end
    $finish;
  end

  // Receiver: random stall per word, with one long hold-off to back the block up
  initial begin
    int  n;
    int  taken;
    bit  rx_quiet;
    bit  held;
    taken = 0;
    rx_quiet = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      n = rx_quiet ? 0 : $urandom_range(0, 11);
      if (taken == HOLD_AT && !held) begin
        n = HOLD_CYCLES;
        held = 1'b1;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  // Compare each accepted result word with the oldest owed one
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word value=%h status=%0d", $time,
                 out_word_o.result_value, out_word_o.status);
        err_cnt++;
      end else begin
        exp_w = owed_words.pop_front();
        if (out_word_o.result_value !== exp_w.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_w.result_value, out_word_o.result_value);
          err_cnt++;
        end
        if (out_word_o.status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_w.status, out_word_o.status);
          err_cnt++;
        end
      end
    end
  end

  // End the run if no word moves on either side for too long
  always @(posedge clk_i) begin
    int idle_cnt;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("queue_from_two_stacks_tb NOT OK");
        $finish;
      end
    end
  end

endmodule

/* files.f */
sv/qfts_pkg.sv
sv/qfts_ctrl.sv
sv/qfts_dp.sv
sv/queue_from_two_stacks.sv
tb/queue_from_two_stacks_tb.sv
